[sv/lcs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_pkg: shared types and constants for the LED chain serializer
// Command codes, register indexes, widths, queue entry and timing bundle.
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int CMD_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 9;
    localparam int TICK_W     = 8;
    localparam int PIX_W      = 3 * BYTE_W;
    localparam int BITCNT_W   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;

    localparam logic [BITCNT_W-1:0] LAST_BIT = BITCNT_W'(PIX_W - 1);

    localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd4;

    localparam logic [CNT_W-1:0]  RST_LED_COUNT = 9'd0;
    localparam logic [TICK_W-1:0] RST_ZERO_HIGH = 8'd3;
    localparam logic [TICK_W-1:0] RST_ZERO_LOW  = 8'd7;
    localparam logic [TICK_W-1:0] RST_ONE_HIGH  = 8'd6;
    localparam logic [TICK_W-1:0] RST_ONE_LOW   = 8'd4;

    typedef enum logic [1:0] {
        OP_SET,
        OP_START,
        OP_TICK,
        OP_NOP
    } t_op_e;

    typedef struct packed {
        t_op_e              op;
        logic               in_range;
        logic [BYTE_W-1:0]  led_index;
        logic [PIX_W-1:0]   color;      // green, red, blue from MSB down
    } t_qent;

    typedef struct packed {
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
    } t_timing;

    // a zero tick count behaves as one tick
    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] t);
        return (t == '0) ? TICK_W'(1) : t;
    endfunction

endpackage
`default_nettype wire

[sv/lcs_item_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_item_if: command item channel
// valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
interface lcs_item_if
    import lcs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] led_index;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;

    modport source (output valid, command, led_index, red, green, blue, input ready);
    modport sink   (input valid, command, led_index, red, green, blue, output ready);
endinterface
`default_nettype wire

[sv/lcs_res_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_res_if: result channel
// valid/ready handshake carrying the line level and busy flag.
// ----------------------------------------------------------------------------
interface lcs_res_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic busy_res;

    modport source (output valid, pin_level, busy_res, input ready);
    modport sink   (input valid, pin_level, busy_res, output ready);
endinterface
`default_nettype wire

[sv/lcs_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_cfg_if: configuration write channel
// valid/ready handshake carrying a register index and write data.
// ----------------------------------------------------------------------------
interface lcs_cfg_if
    import lcs_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/lcs_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[sv/lcs_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_front: command intake
// Accepts items, decodes the command and range-checks the LED index, and
// holds them in a short queue for the serializer.
// ----------------------------------------------------------------------------
module lcs_front
    import lcs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    lcs_item_if.sink              i_item,
    input  wire logic [CNT_W-1:0] i_active,
    output logic                  o_q_valid,
    output t_qent                 o_q_item,
    input  wire logic             i_q_pop
);
    t_qent                r_mem [QDEPTH];
    logic [QPTR_W-1:0]    r_wr;
    logic [QPTR_W-1:0]    r_rd;
    logic [QPTR_W:0]      r_count;
    t_qent                ent;
    logic                 push;
    logic                 pop;

    always_comb begin
        case (i_item.command)
            CMD_SET:   ent.op = OP_SET;
            CMD_START: ent.op = OP_START;
            CMD_TICK:  ent.op = OP_TICK;
            default:   ent.op = OP_NOP;
        endcase
        ent.in_range  = CNT_W'(i_item.led_index) < i_active;
        ent.led_index = i_item.led_index;
        ent.color     = {i_item.green, i_item.red, i_item.blue};
    end

    assign i_item.ready = (r_count != (QPTR_W + 1)'(QDEPTH));
    assign push         = i_item.valid && i_item.ready;
    assign pop          = i_q_pop && o_q_valid;
    assign o_q_valid    = (r_count != '0);
    assign o_q_item     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_mem[r_wr] <= ent;
                r_wr        <= r_wr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + (QPTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end
endmodule
`default_nettype wire

[sv/lcs_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_back: pixel store and bit serializer
// Executes queued commands: writes LED rows, runs the high/low phase timer
// per bit, prefetches the next LED row, and registers one result per item.
// ----------------------------------------------------------------------------
module lcs_back
    import lcs_pkg::*;
#(
    parameter int MAX_LEDS = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire t_qent            i_q_item,
    output logic                  o_q_pop,
    input  wire logic [CNT_W-1:0] i_active,
    input  wire t_timing          i_timing,
    lcs_res_if.source             o_res
);
    localparam int LED_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int DEPTH = 1 << LED_W;

    typedef enum logic {
        S_RUN,
        S_LOAD
    } t_state_e;

    t_state_e             r_state,   n_state;
    logic                 r_sending, n_sending;
    logic                 r_high,    n_high;
    logic [TICK_W-1:0]    r_ticks,   n_ticks;
    logic [BITCNT_W-1:0]  r_bitcnt,  n_bitcnt;
    logic [LED_W-1:0]     r_led,     n_led;
    logic [PIX_W-1:0]     r_pix,     n_pix;
    logic [PIX_W-1:0]     r_next,    n_next;
    logic                 r_fetch,   n_fetch;
    logic                 r_ovalid,  n_ovalid;
    logic                 r_opin,    n_opin;
    logic                 r_obusy,   n_obusy;
    logic                 r_vld [DEPTH];
    logic                 r_rd_vld;

    logic                 out_free;
    logic                 we;
    logic                 re;
    logic [LED_W-1:0]     raddr;
    logic [PIX_W-1:0]     rdata;
    logic [PIX_W-1:0]     data_m;
    logic [CNT_W-1:0]     led_p1;
    logic [CNT_W-1:0]     led_p2;

    lcs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_q_item.led_index[LED_W-1:0]),
        .i_wdata (i_q_item.color),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // rows never written read as zero
    assign data_m   = r_rd_vld ? rdata : '0;
    assign out_free = !r_ovalid || o_res.ready;
    assign led_p1   = CNT_W'(r_led) + CNT_W'(1);
    assign led_p2   = CNT_W'(r_led) + CNT_W'(2);

    assign o_res.valid     = r_ovalid;
    assign o_res.pin_level = r_opin;
    assign o_res.busy_res  = r_obusy;

    always_comb begin
        n_state   = r_state;
        n_sending = r_sending;
        n_high    = r_high;
        n_ticks   = r_ticks;
        n_bitcnt  = r_bitcnt;
        n_led     = r_led;
        n_pix     = r_pix;
        n_next    = r_fetch ? data_m : r_next;
        n_fetch   = 1'b0;
        n_ovalid  = r_ovalid && !o_res.ready;
        n_opin    = r_opin;
        n_obusy   = r_obusy;
        o_q_pop   = 1'b0;
        we        = 1'b0;
        re        = 1'b0;
        raddr     = '0;

        case (r_state)
            S_RUN: begin
                if (i_q_valid && out_free) begin
                    o_q_pop  = 1'b1;
                    n_ovalid = 1'b1;
                    n_opin   = r_sending && r_high;
                    n_obusy  = r_sending;
                    case (i_q_item.op)
                        OP_SET: begin
                            we = !r_sending && i_q_item.in_range;
                        end
                        OP_START: begin
                            if (!r_sending && i_active != '0) begin
                                // first row comes out of the RAM next cycle
                                re       = 1'b1;
                                n_state  = S_LOAD;
                                n_ovalid = r_ovalid && !o_res.ready;
                            end
                        end
                        OP_TICK: begin
                            if (r_sending) begin
                                if (r_ticks > TICK_W'(1)) begin
                                    n_ticks = r_ticks - TICK_W'(1);
                                end else if (r_high) begin
                                    n_high  = 1'b0;
                                    n_ticks = at_least_one(r_pix[PIX_W-1] ?
                                              i_timing.one_low : i_timing.zero_low);
                                end else if (r_bitcnt != LAST_BIT) begin
                                    n_pix    = r_pix << 1;
                                    n_bitcnt = r_bitcnt + BITCNT_W'(1);
                                    n_high   = 1'b1;
                                    n_ticks  = at_least_one(r_pix[PIX_W-2] ?
                                               i_timing.one_high : i_timing.zero_high);
                                end else if (led_p1 >= i_active) begin
                                    n_sending = 1'b0;
                                    n_high    = 1'b0;
                                    n_ticks   = '0;
                                end else begin
                                    // next LED row, and prefetch the one after it
                                    n_led    = led_p1[LED_W-1:0];
                                    n_pix    = r_next;
                                    n_bitcnt = '0;
                                    n_high   = 1'b1;
                                    n_ticks  = at_least_one(r_next[PIX_W-1] ?
                                               i_timing.one_high : i_timing.zero_high);
                                    re       = 1'b1;
                                    raddr    = led_p2[LED_W-1:0];
                                    n_fetch  = 1'b1;
                                end
                                n_obusy = n_sending;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOAD: begin
                if (out_free) begin
                    n_state   = S_RUN;
                    n_sending = 1'b1;
                    n_high    = 1'b1;
                    n_pix     = data_m;
                    n_bitcnt  = '0;
                    n_led     = '0;
                    n_ticks   = at_least_one(data_m[PIX_W-1] ?
                                i_timing.one_high : i_timing.zero_high);
                    re        = 1'b1;
                    raddr     = LED_W'(1);
                    n_fetch   = 1'b1;
                    n_ovalid  = 1'b1;
                    n_opin    = 1'b1;
                    n_obusy   = 1'b1;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RUN;
            r_sending <= 1'b0;
            r_high    <= 1'b0;
            r_ticks   <= '0;
            r_bitcnt  <= '0;
            r_led     <= '0;
            r_fetch   <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sending <= n_sending;
            r_high    <= n_high;
            r_ticks   <= n_ticks;
            r_bitcnt  <= n_bitcnt;
            r_led     <= n_led;
            r_fetch   <= n_fetch;
            r_ovalid  <= n_ovalid;
            r_pix     <= n_pix;
            r_next    <= n_next;
            r_opin    <= n_opin;
            r_obusy   <= n_obusy;
        end
    end

    // per-row written flags stand in for clearing the store at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (we) begin
            r_vld[i_q_item.led_index[LED_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (re) begin
            r_rd_vld <= r_vld[raddr];
        end
    end

`ifndef SYNTHESIS
    a_high_needs_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_high |-> r_sending)
        else $error("high phase outside a write");

    a_ticks_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sending |-> (r_ticks != '0))
        else $error("phase timer empty during a write");

    a_bitcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sending |-> (r_bitcnt <= LAST_BIT))
        else $error("bit counter past last bit of a row");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && out_free) |=> (r_sending && r_high && r_ovalid))
        else $error("row load did not start a write");

    a_no_pop_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !o_q_pop)
        else $error("queue popped while loading first row");
`endif
endmodule
`default_nettype wire

[sv/rgb_led_chain_serializer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_led_chain_serializer: single-wire RGB LED chain driver
// Pixel store plus bit serializer with programmable high/low tick counts.
// ----------------------------------------------------------------------------
// Items go into a four-entry queue and are executed in order; every item
// gives exactly one result on o_res, registered after it leaves the queue.
// Set-color, tick and unused items can stream at one per clock while o_res
// takes each result. A start-write that begins a chain passes through a
// load state: the first LED row has to come out of the pixel RAM's
// registered read port. Later rows are prefetched during the current row,
// so row boundaries cost nothing. The store is cleared by per-LED written
// flags at reset, so no clearing pass is needed. Configuration writes are
// taken at any time with ready held high; change registers only while idle.
// ----------------------------------------------------------------------------
module rgb_led_chain_serializer
    import lcs_pkg::*;
#(
    parameter int MAX_LEDS = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lcs_item_if.sink  i_item,
    lcs_res_if.source o_res,
    lcs_cfg_if.sink   i_cfg
);
    logic [CNT_W-1:0] r_led_count;
    t_timing          r_timing;
    logic [CNT_W-1:0] active;
    logic             q_valid;
    t_qent            q_item;
    logic             q_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count        <= RST_LED_COUNT;
            r_timing.zero_high <= RST_ZERO_HIGH;
            r_timing.zero_low  <= RST_ZERO_LOW;
            r_timing.one_high  <= RST_ONE_HIGH;
            r_timing.one_low   <= RST_ONE_LOW;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_LED_COUNT: r_led_count        <= i_cfg.data;
                REG_ZERO_HIGH: r_timing.zero_high <= i_cfg.data[TICK_W-1:0];
                REG_ZERO_LOW:  r_timing.zero_low  <= i_cfg.data[TICK_W-1:0];
                REG_ONE_HIGH:  r_timing.one_high  <= i_cfg.data[TICK_W-1:0];
                REG_ONE_LOW:   r_timing.one_low   <= i_cfg.data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // LED count saturates at MAX_LEDS
    assign active = (r_led_count > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : r_led_count;

    lcs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_active  (active),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    lcs_back #(
        .MAX_LEDS (MAX_LEDS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .i_active  (active),
        .i_timing  (r_timing),
        .o_res     (o_res)
    );
endmodule
`default_nettype wire
